/* src/stt_pkg.sv */
`timescale 1ns / 1ps

package stt_pkg;

   // Token kinds as they appear on the result channel.
   typedef logic [5:0] kind_type;
   typedef logic [1:0] error_type;

   localparam kind_type KIND_EOF       = 6'd0;
   localparam kind_type KIND_LPAREN    = 6'd1;
   localparam kind_type KIND_RPAREN    = 6'd2;
   localparam kind_type KIND_LBRACE    = 6'd3;
   localparam kind_type KIND_RBRACE    = 6'd4;
   localparam kind_type KIND_COMMA     = 6'd5;
   localparam kind_type KIND_SEMICOLON = 6'd6;
   localparam kind_type KIND_COLON     = 6'd7;
   localparam kind_type KIND_DOT       = 6'd8;
   localparam kind_type KIND_MINUS     = 6'd9;
   localparam kind_type KIND_PLUS      = 6'd10;
   localparam kind_type KIND_STAR      = 6'd11;
   localparam kind_type KIND_SLASH     = 6'd12;
   localparam kind_type KIND_PERCENT   = 6'd13;
   localparam kind_type KIND_UNDER     = 6'd14;
   localparam kind_type KIND_AND_AND   = 6'd15;
   localparam kind_type KIND_OR_OR     = 6'd16;
   localparam kind_type KIND_BAR       = 6'd17;
   localparam kind_type KIND_EQ_EQ     = 6'd18;
   localparam kind_type KIND_EQ        = 6'd19;
   localparam kind_type KIND_BANG_EQ   = 6'd20;
   localparam kind_type KIND_BANG      = 6'd21;
   localparam kind_type KIND_LESS_EQ   = 6'd22;
   localparam kind_type KIND_LESS      = 6'd23;
   localparam kind_type KIND_GREATER_EQ = 6'd24;
   localparam kind_type KIND_GREATER   = 6'd25;
   localparam kind_type KIND_IDENT     = 6'd26;
   localparam kind_type KIND_NUMBER    = 6'd27;
   localparam kind_type KIND_STRING    = 6'd28;
   localparam kind_type KIND_ELSE      = 6'd29;
   localparam kind_type KIND_FALSE     = 6'd30;
   localparam kind_type KIND_FOR       = 6'd31;
   localparam kind_type KIND_FN        = 6'd32;
   localparam kind_type KIND_IF        = 6'd33;
   localparam kind_type KIND_LET       = 6'd34;
   localparam kind_type KIND_NIL       = 6'd35;
   localparam kind_type KIND_RETURN    = 6'd36;
   localparam kind_type KIND_TRUE      = 6'd37;
   localparam kind_type KIND_WHILE     = 6'd38;
   localparam kind_type KIND_ERROR     = 6'd39;

   localparam error_type ERR_NONE         = 2'd0;
   localparam error_type ERR_UNEXPECTED   = 2'd1;
   localparam error_type ERR_UNTERMINATED = 2'd2;

   // Depth of the token queue in front of the result channel.
   localparam int unsigned TOKEN_QUEUE_DEPTH = 4;

   // Scanner modes between bytes.
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_SLASH,
      MODE_COMMENT,
      MODE_UNDER,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_STRING,
      MODE_OP
   } mode_type;

   // First six bytes of a word, byte 0 first.
   typedef logic [5:0][7:0] prefix_type;

   // One source byte with its character class, as the front passes it on.
   typedef struct packed {
      logic [7:0] char_byte;
      logic       is_end;
      logic       is_letter;
      logic       is_numeral;
      logic       is_blank;
      logic       is_newline;
      logic       is_quote;
      logic       is_slash;
      logic       is_under;
      logic       is_opchar;
   } item_type;

   // Kind of a byte that is a complete token by itself, KIND_EOF if none.
   function automatic kind_type single_kind(logic [7:0] b);
      kind_type k;
      unique case (b)
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "{":     k = KIND_LBRACE;
         "}":     k = KIND_RBRACE;
         ",":     k = KIND_COMMA;
         ";":     k = KIND_SEMICOLON;
         ":":     k = KIND_COLON;
         ".":     k = KIND_DOT;
         "-":     k = KIND_MINUS;
         "+":     k = KIND_PLUS;
         "*":     k = KIND_STAR;
         "%":     k = KIND_PERCENT;
         default: k = KIND_EOF;
      endcase
      return k;
   endfunction

   // Kind of an operator byte standing alone; KIND_EOF marks a lone ampersand.
   function automatic kind_type op_alone(logic [7:0] c);
      kind_type k;
      unique case (c)
         "|":     k = KIND_BAR;
         "=":     k = KIND_EQ;
         "!":     k = KIND_BANG;
         "<":     k = KIND_LESS;
         ">":     k = KIND_GREATER;
         default: k = KIND_EOF;
      endcase
      return k;
   endfunction

   // Kind of a two-byte operator, KIND_EOF when the pair is not one.
   function automatic kind_type op_pair(logic [7:0] c, logic [7:0] b);
      kind_type k;
      k = KIND_EOF;
      if (c == "&" && b == "&") begin
         k = KIND_AND_AND;
      end else if (c == "|" && b == "|") begin
         k = KIND_OR_OR;
      end else if (b == "=") begin
         unique case (c)
            "=":     k = KIND_EQ_EQ;
            "!":     k = KIND_BANG_EQ;
            "<":     k = KIND_LESS_EQ;
            ">":     k = KIND_GREATER_EQ;
            default: k = KIND_EOF;
         endcase
      end
      return k;
   endfunction

   // Keyword match on an exact word length; len is 7 for any longer word.
   function automatic kind_type kw_kind(prefix_type p, logic [2:0] len);
      kind_type k;
      k = KIND_IDENT;
      unique case (len)
         3'd2: begin
            if (p[0] == "f" && p[1] == "n") k = KIND_FN;
            else if (p[0] == "i" && p[1] == "f") k = KIND_IF;
         end
         3'd3: begin
            if (p[0] == "f" && p[1] == "o" && p[2] == "r") k = KIND_FOR;
            else if (p[0] == "l" && p[1] == "e" && p[2] == "t") k = KIND_LET;
            else if (p[0] == "n" && p[1] == "i" && p[2] == "l") k = KIND_NIL;
         end
         3'd4: begin
            if (p[0] == "e" && p[1] == "l" && p[2] == "s" && p[3] == "e") k = KIND_ELSE;
            else if (p[0] == "t" && p[1] == "r" && p[2] == "u" && p[3] == "e") k = KIND_TRUE;
         end
         3'd5: begin
            if (p[0] == "f" && p[1] == "a" && p[2] == "l" && p[3] == "s" && p[4] == "e") begin
               k = KIND_FALSE;
            end else if (p[0] == "w" && p[1] == "h" && p[2] == "i" && p[3] == "l"
                         && p[4] == "e") begin
               k = KIND_WHILE;
            end
         end
         3'd6: begin
            if (p[0] == "r" && p[1] == "e" && p[2] == "t" && p[3] == "u" && p[4] == "r"
                && p[5] == "n") begin
               k = KIND_RETURN;
            end
         end
         default: k = KIND_IDENT;
      endcase
      return k;
   endfunction

endpackage

/* src/stt_front.sv */
`timescale 1ns / 1ps

module stt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_char_byte,
   input  logic              req_end_of_text,
   output logic              item_valid,
   input  logic              item_ready,
   output stt_pkg::item_type item
);

   stt_pkg::item_type entries_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   stt_pkg::item_type classified;
   logic              push;
   logic              pop;

   // Classify the incoming byte before it enters the queue.
   always_comb begin
      classified.char_byte  = req_char_byte;
      classified.is_end     = req_end_of_text || (req_char_byte == 8'd0);
      classified.is_letter  = (req_char_byte >= "a" && req_char_byte <= "z")
                              || (req_char_byte >= "A" && req_char_byte <= "Z");
      classified.is_numeral = (req_char_byte >= "0" && req_char_byte <= "9");
      classified.is_blank   = (req_char_byte == " ") || (req_char_byte == "\t")
                              || (req_char_byte == "\r");
      classified.is_newline = (req_char_byte == "\n");
      classified.is_quote   = (req_char_byte == "\"");
      classified.is_slash   = (req_char_byte == "/");
      classified.is_under   = (req_char_byte == "_");
      classified.is_opchar  = (req_char_byte == "&")
                              || (stt_pkg::op_alone(req_char_byte) != stt_pkg::KIND_EOF);
   end

   // Two-entry queue toward the scanner.
   assign req_ready  = (count_ff != 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = entries_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

/* src/stt_back.sv */
`timescale 1ns / 1ps

module stt_back #(
   parameter int OFFSET_WIDTH = 32,
   parameter int LENGTH_WIDTH = 16,
   parameter int LINE_WIDTH   = 24,
   localparam int TOKEN_WIDTH = 6 + 2 + OFFSET_WIDTH + LENGTH_WIDTH + LINE_WIDTH + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  stt_pkg::item_type      in_item,
   input  logic                   out_room,
   output logic [1:0]             wr_count,
   output logic [TOKEN_WIDTH-1:0] wr_data0,
   output logic [TOKEN_WIDTH-1:0] wr_data1
);

   localparam logic [LENGTH_WIDTH-1:0] LEN_MAX  = '1;
   localparam logic [LENGTH_WIDTH-1:0] LEN_ONE  = LENGTH_WIDTH'(1);
   localparam logic [LENGTH_WIDTH-1:0] LEN_TWO  = LENGTH_WIDTH'(2);
   localparam logic [LENGTH_WIDTH-1:0] LEN_SIX  = LENGTH_WIDTH'(6);
   localparam logic [LENGTH_WIDTH-1:0] LEN_SEVEN = LENGTH_WIDTH'(7);
   localparam logic [LINE_WIDTH-1:0]   LINE_MAX = '1;
   localparam logic [LINE_WIDTH-1:0]   LINE_ONE = LINE_WIDTH'(1);

   stt_pkg::mode_type          mode_ff, mode_in;
   logic [7:0]                 pend_ff, pend_in;
   stt_pkg::prefix_type        prefix_ff, prefix_in;
   logic [OFFSET_WIDTH-1:0]    begin_ff, begin_in;
   logic [LENGTH_WIDTH-1:0]    runlen_ff, runlen_in;
   logic [OFFSET_WIDTH-1:0]    pos_ff, pos_in;
   logic [LINE_WIDTH-1:0]      line_ff, line_in;

   logic                       take;
   logic [7:0]                 b;
   logic                       start_go;
   logic                       is_other;
   logic [LENGTH_WIDTH-1:0]    run_grown;
   logic [2:0]                 word_len;
   stt_pkg::kind_type          word_kind;
   stt_pkg::kind_type          pair_kind;
   stt_pkg::kind_type          alone_kind;
   stt_pkg::kind_type          one_kind;

   logic                       t0_valid, t1_valid;
   stt_pkg::kind_type          t0_kind, t1_kind;
   stt_pkg::error_type         t0_err, t1_err;
   logic [OFFSET_WIDTH-1:0]    t0_begin, t1_begin;
   logic [LENGTH_WIDTH-1:0]    t0_len, t1_len;
   logic [TOKEN_WIDTH-1:0]     tok0, tok1;

   // A byte is taken only when the token queue can hold two more tokens.
   assign in_ready = out_room;
   assign take     = in_valid && out_room;
   assign b        = in_item.char_byte;

   // Shared decode of the current mode and byte.
   assign run_grown  = (runlen_ff == LEN_MAX) ? runlen_ff : runlen_ff + LEN_ONE;
   assign word_len   = (runlen_ff < LEN_SEVEN) ? runlen_ff[2:0] : 3'd7;
   assign word_kind  = stt_pkg::kw_kind(prefix_ff, word_len);
   assign pair_kind  = stt_pkg::op_pair(pend_ff, b);
   assign alone_kind = stt_pkg::op_alone(pend_ff);
   assign one_kind   = stt_pkg::single_kind(b);
   assign is_other   = !(in_item.is_blank || in_item.is_newline || in_item.is_letter
                         || in_item.is_numeral || in_item.is_quote || in_item.is_slash
                         || in_item.is_under || in_item.is_opchar);

   // Whether this byte ends the current mode and starts a fresh token.
   always_comb begin
      start_go = 1'b0;
      if (!in_item.is_end) begin
         unique case (mode_ff)
            stt_pkg::MODE_IDLE:    start_go = 1'b1;
            stt_pkg::MODE_SLASH:   start_go = !in_item.is_slash;
            stt_pkg::MODE_COMMENT: start_go = in_item.is_newline;
            stt_pkg::MODE_UNDER:   start_go = !(in_item.is_letter || in_item.is_numeral);
            stt_pkg::MODE_IDENT:   start_go = !(in_item.is_letter || in_item.is_numeral
                                                || in_item.is_under);
            stt_pkg::MODE_NUMBER:  start_go = !(in_item.is_numeral || b == ".");
            stt_pkg::MODE_STRING:  start_go = 1'b0;
            stt_pkg::MODE_OP:      start_go = (pair_kind == stt_pkg::KIND_EOF);
         endcase
      end
   end

   // Next scanner state.
   always_comb begin
      mode_in   = mode_ff;
      pend_in   = pend_ff;
      prefix_in = prefix_ff;
      begin_in  = begin_ff;
      runlen_in = runlen_ff;
      pos_in    = pos_ff;
      line_in   = line_ff;
      if (take) begin
         if (in_item.is_end) begin
            // End of text returns everything to the reset values.
            mode_in   = stt_pkg::MODE_IDLE;
            pend_in   = 8'd0;
            prefix_in = '0;
            begin_in  = '0;
            runlen_in = '0;
            pos_in    = '0;
            line_in   = LINE_ONE;
         end else begin
            pos_in = pos_ff + OFFSET_WIDTH'(1);
            unique case (mode_ff)
               stt_pkg::MODE_SLASH: begin
                  if (in_item.is_slash) mode_in = stt_pkg::MODE_COMMENT;
               end
               stt_pkg::MODE_UNDER: begin
                  if (in_item.is_letter || in_item.is_numeral) begin
                     prefix_in    = '0;
                     prefix_in[0] = "_";
                     prefix_in[1] = b;
                     runlen_in    = LEN_TWO;
                     mode_in      = stt_pkg::MODE_IDENT;
                  end
               end
               stt_pkg::MODE_IDENT, stt_pkg::MODE_NUMBER: begin
                  if (!start_go) begin
                     if (runlen_ff < LEN_SIX) prefix_in[runlen_ff[2:0]] = b;
                     runlen_in = run_grown;
                  end
               end
               stt_pkg::MODE_STRING: begin
                  if (runlen_ff < LEN_SIX) prefix_in[runlen_ff[2:0]] = b;
                  runlen_in = run_grown;
                  if (in_item.is_quote) mode_in = stt_pkg::MODE_IDLE;
               end
               stt_pkg::MODE_OP: begin
                  if (!start_go) mode_in = stt_pkg::MODE_IDLE;
               end
               stt_pkg::MODE_IDLE, stt_pkg::MODE_COMMENT: begin
                  mode_in = mode_ff;
               end
            endcase
            // A new token starts at this byte.
            if (start_go) begin
               mode_in   = stt_pkg::MODE_IDLE;
               begin_in  = pos_ff;
               runlen_in = LEN_ONE;
               priority if (in_item.is_newline) begin
                  if (line_ff != LINE_MAX) line_in = line_ff + LINE_ONE;
               end else if (in_item.is_letter) begin
                  prefix_in    = '0;
                  prefix_in[0] = b;
                  mode_in      = stt_pkg::MODE_IDENT;
               end else if (in_item.is_numeral) begin
                  mode_in = stt_pkg::MODE_NUMBER;
               end else if (in_item.is_quote) begin
                  mode_in = stt_pkg::MODE_STRING;
               end else if (in_item.is_slash) begin
                  mode_in = stt_pkg::MODE_SLASH;
               end else if (in_item.is_under) begin
                  mode_in = stt_pkg::MODE_UNDER;
               end else if (in_item.is_opchar) begin
                  pend_in = b;
                  mode_in = stt_pkg::MODE_OP;
               end else begin
                  mode_in = stt_pkg::MODE_IDLE;
               end
            end
         end
      end
   end

   // Tokens of this byte: t0 closes the pending token, t1 is a fresh one or eof.
   always_comb begin
      t0_valid = 1'b0;
      t0_kind  = stt_pkg::KIND_EOF;
      t0_err   = stt_pkg::ERR_NONE;
      t0_begin = begin_ff;
      t0_len   = LEN_ONE;
      t1_valid = 1'b0;
      t1_kind  = stt_pkg::KIND_EOF;
      t1_err   = stt_pkg::ERR_NONE;
      t1_begin = pos_ff;
      t1_len   = '0;
      if (in_item.is_end) begin
         t1_valid = 1'b1;
         unique case (mode_ff)
            stt_pkg::MODE_SLASH: begin
               t0_valid = 1'b1;
               t0_kind  = stt_pkg::KIND_SLASH;
            end
            stt_pkg::MODE_UNDER: begin
               t0_valid = 1'b1;
               t0_kind  = stt_pkg::KIND_UNDER;
            end
            stt_pkg::MODE_IDENT: begin
               t0_valid = 1'b1;
               t0_kind  = word_kind;
               t0_len   = runlen_ff;
            end
            stt_pkg::MODE_NUMBER: begin
               t0_valid = 1'b1;
               t0_kind  = stt_pkg::KIND_NUMBER;
               t0_len   = runlen_ff;
            end
            stt_pkg::MODE_STRING: begin
               t0_valid = 1'b1;
               t0_kind  = stt_pkg::KIND_ERROR;
               t0_err   = stt_pkg::ERR_UNTERMINATED;
               t0_len   = runlen_ff;
            end
            stt_pkg::MODE_OP: begin
               t0_valid = 1'b1;
               if (alone_kind == stt_pkg::KIND_EOF) begin
                  t0_kind = stt_pkg::KIND_ERROR;
                  t0_err  = stt_pkg::ERR_UNEXPECTED;
               end else begin
                  t0_kind = alone_kind;
               end
            end
            stt_pkg::MODE_IDLE, stt_pkg::MODE_COMMENT: begin
               t0_valid = 1'b0;
            end
         endcase
      end else begin
         unique case (mode_ff)
            stt_pkg::MODE_SLASH: begin
               t0_valid = start_go;
               t0_kind  = stt_pkg::KIND_SLASH;
            end
            stt_pkg::MODE_UNDER: begin
               t0_valid = start_go;
               t0_kind  = stt_pkg::KIND_UNDER;
            end
            stt_pkg::MODE_IDENT: begin
               t0_valid = start_go;
               t0_kind  = word_kind;
               t0_len   = runlen_ff;
            end
            stt_pkg::MODE_NUMBER: begin
               t0_valid = start_go;
               t0_kind  = stt_pkg::KIND_NUMBER;
               t0_len   = runlen_ff;
            end
            stt_pkg::MODE_STRING: begin
               t0_valid = in_item.is_quote;
               t0_kind  = stt_pkg::KIND_STRING;
               t0_len   = run_grown;
            end
            stt_pkg::MODE_OP: begin
               t0_valid = 1'b1;
               if (!start_go) begin
                  t0_kind = pair_kind;
                  t0_len  = LEN_TWO;
               end else if (alone_kind == stt_pkg::KIND_EOF) begin
                  t0_kind = stt_pkg::KIND_ERROR;
                  t0_err  = stt_pkg::ERR_UNEXPECTED;
               end else begin
                  t0_kind = alone_kind;
               end
            end
            stt_pkg::MODE_IDLE, stt_pkg::MODE_COMMENT: begin
               t0_valid = 1'b0;
            end
         endcase
         // Bytes that are a whole token, or fit no token at all.
         if (start_go && is_other) begin
            t1_valid = 1'b1;
            t1_len   = LEN_ONE;
            if (one_kind == stt_pkg::KIND_EOF) begin
               t1_kind = stt_pkg::KIND_ERROR;
               t1_err  = stt_pkg::ERR_UNEXPECTED;
            end else begin
               t1_kind = one_kind;
            end
         end
      end
   end

   // Pack and compact the tokens into the queue write slots.
   assign tok0 = {t0_kind, t0_err, t0_begin, t0_len, line_ff, !t1_valid};
   assign tok1 = {t1_kind, t1_err, t1_begin, t1_len, line_ff, 1'b1};

   assign wr_count = take ? ({1'b0, t0_valid} + {1'b0, t1_valid}) : 2'd0;
   assign wr_data0 = t0_valid ? tok0 : tok1;
   assign wr_data1 = tok1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= stt_pkg::MODE_IDLE;
         pend_ff   <= 8'd0;
         prefix_ff <= '0;
         begin_ff  <= '0;
         runlen_ff <= '0;
         pos_ff    <= '0;
         line_ff   <= LINE_ONE;
      end else begin
         mode_ff   <= mode_in;
         pend_ff   <= pend_in;
         prefix_ff <= prefix_in;
         begin_ff  <= begin_in;
         runlen_ff <= runlen_in;
         pos_ff    <= pos_in;
         line_ff   <= line_in;
      end
   end

endmodule

/* src/stt_token_queue.sv */
`timescale 1ns / 1ps

module stt_token_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       wr_count,
   input  logic [WIDTH-1:0] wr_data0,
   input  logic [WIDTH-1:0] wr_data1,
   output logic             room,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_WIDTH = $clog2(DEPTH);
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]     entries_ff [DEPTH];
   logic [PTR_WIDTH-1:0] head_ff, head_in;
   logic [PTR_WIDTH-1:0] tail_ff, tail_in;
   logic [PTR_WIDTH-1:0] tail_next;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 pop;

   function automatic logic [PTR_WIDTH-1:0] ptr_inc(logic [PTR_WIDTH-1:0] p);
      return (p == PTR_WIDTH'(DEPTH - 1)) ? '0 : p + PTR_WIDTH'(1);
   endfunction

   // Room means two tokens fit, enough for any one byte.
   assign room      = (count_ff <= CNT_WIDTH'(DEPTH - 2));
   assign rd_valid  = (count_ff != '0);
   assign rd_data   = entries_ff[head_ff];
   assign pop       = rd_valid && rd_ready;
   assign tail_next = ptr_inc(tail_ff);

   always_comb begin
      head_in  = pop ? ptr_inc(head_ff) : head_ff;
      unique case (wr_count)
         2'd1:    tail_in = tail_next;
         2'd2:    tail_in = ptr_inc(tail_next);
         default: tail_in = tail_ff;
      endcase
      count_in = count_ff + CNT_WIDTH'(wr_count) - CNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Up to two tokens are written per cycle, in order.
   always_ff @(posedge clock) begin
      if (wr_count != 2'd0) begin
         entries_ff[tail_ff] <= wr_data0;
      end
      if (wr_count == 2'd2) begin
         entries_ff[tail_next] <= wr_data1;
      end
   end

endmodule

/* src/source_text_tokenizer.sv */
`timescale 1ns / 1ps

// Streaming tokenizer. Source bytes arrive one per beat on the req_ channel
// (valid/ready); req_end_of_text, or a zero byte, closes the text. Each
// completed token leaves as one beat on the rsp_ channel with its kind, error
// kind, start offset, length, line and a flag on the last token of a byte.
// A byte yields zero, one or two tokens; end of text flushes any open token
// and then gives an eof token, after which a new text starts at offset 0,
// line 1.
// Throughput is one byte per cycle. The scanner takes a byte when the
// four-entry token queue has room for two tokens, and the queue drains one
// token per cycle, so the rate holds while tokens per byte average one or
// less. An accepted byte is held in the two-entry byte queue, and its tokens
// then in the token queue, before they reach rsp_. When the receiver
// stalls, the token queue fills, the scanner stops, the byte queue fills
// and req_ready drops. Reset empties both queues and puts the scanner
// between tokens at offset 0, line 1.
module source_text_tokenizer #(
   parameter int OFFSET_WIDTH = 32,
   parameter int LENGTH_WIDTH = 16,
   parameter int LINE_WIDTH   = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_char_byte,
   input  logic                    req_end_of_text,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [5:0]              rsp_token_kind,
   output logic [1:0]              rsp_error_kind,
   output logic [OFFSET_WIDTH-1:0] rsp_token_offset,
   output logic [LENGTH_WIDTH-1:0] rsp_token_length,
   output logic [LINE_WIDTH-1:0]   rsp_line_number,
   output logic                    rsp_last_of_run
);

   localparam int TOKEN_WIDTH = 6 + 2 + OFFSET_WIDTH + LENGTH_WIDTH + LINE_WIDTH + 1;

   stt_pkg::item_type      item;
   logic                   item_valid;
   logic                   item_ready;
   logic                   room;
   logic [1:0]             wr_count;
   logic [TOKEN_WIDTH-1:0] wr_data0;
   logic [TOKEN_WIDTH-1:0] wr_data1;
   logic [TOKEN_WIDTH-1:0] head_data;

   // Byte classification and input queue.
   stt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_byte   (req_char_byte),
      .req_end_of_text (req_end_of_text),
      .item_valid      (item_valid),
      .item_ready      (item_ready),
      .item            (item)
   );

   // Scanner state machine.
   stt_back #(
      .OFFSET_WIDTH (OFFSET_WIDTH),
      .LENGTH_WIDTH (LENGTH_WIDTH),
      .LINE_WIDTH   (LINE_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (item_valid),
      .in_ready (item_ready),
      .in_item  (item),
      .out_room (room),
      .wr_count (wr_count),
      .wr_data0 (wr_data0),
      .wr_data1 (wr_data1)
   );

   // Token queue feeding the result channel.
   stt_token_queue #(
      .WIDTH (TOKEN_WIDTH),
      .DEPTH (stt_pkg::TOKEN_QUEUE_DEPTH)
   ) u_token_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_count (wr_count),
      .wr_data0 (wr_data0),
      .wr_data1 (wr_data1),
      .room     (room),
      .rd_valid (rsp_valid),
      .rd_ready (rsp_ready),
      .rd_data  (head_data)
   );

   assign {rsp_token_kind, rsp_error_kind, rsp_token_offset, rsp_token_length,
           rsp_line_number, rsp_last_of_run} = head_data;

endmodule
